[design/vector_rotator_unit_defines.svh]
// ============================================================================
// vector_rotator_unit_defines.svh
// Assertion macros shared by the vector rotator RTL. Each one is clocked on
// i_clk and is disabled while i_rst_n is low.
// ============================================================================
`ifndef VECTOR_ROTATOR_UNIT_DEFINES_SVH
`define VECTOR_ROTATOR_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define VRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies the consequent in the same cycle
`define VRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies the consequent in the next cycle
`define VRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vru_pkg.sv]
// ============================================================================
// vru_pkg
// Types, formats and constants of the CORDIC vector rotator.
// ============================================================================
package vru_pkg;

    // Component format: signed Q16.16
    localparam int COMP_W = 32;
    // Input angle: signed Q4.28 radians
    localparam int ANG_W = 32;
    // Guard bits below the Q16.16 point in the rotation datapath
    localparam int GUARD = 8;
    // Rotation datapath: headroom for sqrt(2) and CORDIC growth
    localparam int DP_W = COMP_W + GUARD + 3;
    // Angle datapath: Q.30 with room for the x4 scale and the reduction
    localparam int Z_W = ANG_W + 3;

    // Default micro-rotation count (valid 12..32)
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int ATAN_N = 32;

    // Gain compensation: K in Q0.30, magnitude split at LO_W bits
    localparam int K_W = 30;
    localparam int K_FRAC = 30;
    localparam int MAG_W = COMP_W;
    localparam int LO_W = 24;
    localparam int HI_W = MAG_W - LO_W;
    localparam int SHIFT_C = K_FRAC - GUARD;
    localparam int SHIFT_UP = LO_W - SHIFT_C;
    localparam int HP_W = HI_W + K_W;
    localparam int LP_W = LO_W + K_W;
    localparam logic [K_W-1:0] GAIN_K = K_W'(64'd652032874);

    // Angle constants in Q.30
    localparam logic signed [Z_W-1:0] ANG_PI = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0] ANG_2PI = Z_W'(64'sd6746518852);
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = Z_W'(64'sd1686629713);

    // atan(2^-i) in Q.30, truncated
    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    // Output clip limits
    localparam logic signed [COMP_W-1:0] OUT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] OUT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // Input word
    typedef struct packed {
        logic signed [COMP_W-1:0] x_in;
        logic signed [COMP_W-1:0] y_in;
        logic signed [ANG_W-1:0]  angle;
    } t_vru_in;

    // Result word
    typedef struct packed {
        logic signed [COMP_W-1:0] x_out;
        logic signed [COMP_W-1:0] y_out;
        logic                     saturated;
    } t_vru_out;

    // Vector and residual angle between rotation stages
    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vru_rot;

endpackage

[design/vru_cordic_step.sv]
// ============================================================================
// vru_cordic_step
// One registered CORDIC micro-rotation by atan(2^-STEP), rotation mode.
// ============================================================================
module vru_cordic_step #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  vru_pkg::t_vru_rot i_rot,
    output logic              o_vld,
    output vru_pkg::t_vru_rot o_rot
);

    localparam logic signed [vru_pkg::Z_W-1:0] ATAN_Z =
        vru_pkg::Z_W'(vru_pkg::ATAN_Q30[STEP]);

    logic                              r_vld;
    vru_pkg::t_vru_rot                 r_rot;
    vru_pkg::t_vru_rot                 n_rot;
    logic signed [vru_pkg::DP_W-1:0]   dx;
    logic signed [vru_pkg::DP_W-1:0]   dy;

    // Shifted cross terms, floor rounding
    assign dx = i_rot.y >>> STEP;
    assign dy = i_rot.x >>> STEP;

    // Turn toward zero residual; zero counts as positive
    always_comb begin
        if (!i_rot.z[vru_pkg::Z_W-1]) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - ATAN_Z;
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + ATAN_Z;
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;

endmodule

[design/vector_rotator_unit.sv]
// ============================================================================
// vector_rotator_unit
// Rotates a Q16.16 vector by a Q4.28 radian angle with a pipelined CORDIC.
// A word is taken on every clock edge with start high; busy is always low, so
// one rotation enters per clock. Each result shows on o_data for a single
// cycle with o_valid high, in input order; the receiver cannot hold it off.
// Each word passes three front stages (angle reduction, quadrant fold with
// the gain multiplies, gain sum), one register per micro-rotation, and the
// rounding and clip register. Results out of Q16.16 range clip and set
// saturated.
// ============================================================================
`include "vector_rotator_unit_defines.svh"

module vector_rotator_unit #(
    parameter int CORDIC_STEPS = vru_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vru_pkg::t_vru_in  i_data,
    output logic              o_valid,
    output vru_pkg::t_vru_out o_data
);

    localparam int DP_W = vru_pkg::DP_W;
    localparam int Z_W = vru_pkg::Z_W;
    localparam int MAG_W = vru_pkg::MAG_W;
    localparam int LO_W = vru_pkg::LO_W;
    localparam logic signed [DP_W-1:0] ROUND = DP_W'(1) <<< (vru_pkg::GUARD - 1);
    localparam logic signed [DP_W-1:0] SAT_HI = DP_W'(vru_pkg::OUT_MAX);
    localparam logic signed [DP_W-1:0] SAT_LO = DP_W'(vru_pkg::OUT_MIN);
    localparam logic signed [Z_W-1:0] NEG_PI = -vru_pkg::ANG_PI;
    localparam logic signed [Z_W-1:0] NEG_HALF_PI = -vru_pkg::ANG_HALF_PI;

    // ------------------------------------------------------------------
    // Stage 1: angle x4 to Q.30, reduce into [-pi, pi], take magnitudes
    // ------------------------------------------------------------------
    logic                    r_s1_vld;
    logic signed [Z_W-1:0]   r_s1_z;
    logic [MAG_W-1:0]        r_s1_mx;
    logic [MAG_W-1:0]        r_s1_my;
    logic                    r_s1_nx;
    logic                    r_s1_ny;
    logic signed [Z_W-1:0]   z4;
    logic signed [Z_W-1:0]   n_s1_z;

    assign busy = 1'b0;

    assign z4 = {{(Z_W - vru_pkg::ANG_W - 2){i_data.angle[vru_pkg::ANG_W-1]}},
                 i_data.angle, 2'b00};

    // One 2*pi correction reaches every Q4.28 angle; +-pi stays as is
    always_comb begin
        priority if (z4 > vru_pkg::ANG_PI) begin
            n_s1_z = z4 - vru_pkg::ANG_2PI;
        end else if (z4 < NEG_PI) begin
            n_s1_z = z4 + vru_pkg::ANG_2PI;
        end else begin
            n_s1_z = z4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    // Magnitude of the most negative input still fits MAG_W unsigned bits
    always_ff @(posedge i_clk) begin
        r_s1_z  <= n_s1_z;
        r_s1_mx <= i_data.x_in[vru_pkg::COMP_W-1] ? MAG_W'(-i_data.x_in) : MAG_W'(i_data.x_in);
        r_s1_my <= i_data.y_in[vru_pkg::COMP_W-1] ? MAG_W'(-i_data.y_in) : MAG_W'(i_data.y_in);
        r_s1_nx <= i_data.x_in[vru_pkg::COMP_W-1];
        r_s1_ny <= i_data.y_in[vru_pkg::COMP_W-1];
    end

    // ------------------------------------------------------------------
    // Stage 2: fold into [-pi/2, pi/2], gain partial products
    // ------------------------------------------------------------------
    logic                         r_s2_vld;
    logic signed [Z_W-1:0]        r_s2_z;
    logic                         r_s2_sx;
    logic                         r_s2_sy;
    logic [vru_pkg::HP_W-1:0]     r_s2_hx;
    logic [vru_pkg::LP_W-1:0]     r_s2_lx;
    logic [vru_pkg::HP_W-1:0]     r_s2_hy;
    logic [vru_pkg::LP_W-1:0]     r_s2_ly;
    logic signed [Z_W-1:0]        n_s2_z;
    logic                         fold;

    // Outer half-planes: move the angle by pi and flip the vector
    always_comb begin
        priority if (r_s1_z > vru_pkg::ANG_HALF_PI) begin
            n_s2_z = r_s1_z - vru_pkg::ANG_PI;
            fold   = 1'b1;
        end else if (r_s1_z < NEG_HALF_PI) begin
            n_s2_z = r_s1_z + vru_pkg::ANG_PI;
            fold   = 1'b1;
        end else begin
            n_s2_z = r_s1_z;
            fold   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // Flip only moves the sign; magnitude goes through the split multiply
    always_ff @(posedge i_clk) begin
        r_s2_z  <= n_s2_z;
        r_s2_sx <= r_s1_nx ^ fold;
        r_s2_sy <= r_s1_ny ^ fold;
        r_s2_hx <= vru_pkg::HP_W'(r_s1_mx[MAG_W-1:LO_W]) * vru_pkg::HP_W'(vru_pkg::GAIN_K);
        r_s2_lx <= vru_pkg::LP_W'(r_s1_mx[LO_W-1:0]) * vru_pkg::LP_W'(vru_pkg::GAIN_K);
        r_s2_hy <= vru_pkg::HP_W'(r_s1_my[MAG_W-1:LO_W]) * vru_pkg::HP_W'(vru_pkg::GAIN_K);
        r_s2_ly <= vru_pkg::LP_W'(r_s1_my[LO_W-1:0]) * vru_pkg::LP_W'(vru_pkg::GAIN_K);
    end

    // ------------------------------------------------------------------
    // Stage 3: gain sum to Q.24, sign applied (rounds toward zero)
    // ------------------------------------------------------------------
    logic                    r_s3_vld;
    vru_pkg::t_vru_rot       r_s3_rot;
    vru_pkg::t_vru_rot       n_s3_rot;
    logic [DP_W-1:0]         px;
    logic [DP_W-1:0]         py;

    assign px = (DP_W'(r_s2_hx) << vru_pkg::SHIFT_UP) + DP_W'(r_s2_lx >> vru_pkg::SHIFT_C);
    assign py = (DP_W'(r_s2_hy) << vru_pkg::SHIFT_UP) + DP_W'(r_s2_ly >> vru_pkg::SHIFT_C);

    always_comb begin
        n_s3_rot.x = r_s2_sx ? $signed(-px) : $signed(px);
        n_s3_rot.y = r_s2_sy ? $signed(-py) : $signed(py);
        n_s3_rot.z = r_s2_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_rot <= n_s3_rot;
    end

    // ------------------------------------------------------------------
    // Micro-rotation pipeline, one register stage per step
    // ------------------------------------------------------------------
    logic              vld_chain [CORDIC_STEPS+1];
    vru_pkg::t_vru_rot rot_chain [CORDIC_STEPS+1];

    assign vld_chain[0] = r_s3_vld;
    assign rot_chain[0] = r_s3_rot;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        vru_cordic_step #(
            .STEP (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld_chain[g]),
            .i_rot   (rot_chain[g]),
            .o_vld   (vld_chain[g+1]),
            .o_rot   (rot_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output: round half up to Q16.16, clip, register the result word
    // ------------------------------------------------------------------
    logic                    r_out_vld;
    vru_pkg::t_vru_out       r_out;
    vru_pkg::t_vru_out       n_out;
    logic signed [DP_W-1:0]  xr;
    logic signed [DP_W-1:0]  yr;
    logic                    clip_x;
    logic                    clip_y;

    assign xr = (rot_chain[CORDIC_STEPS].x + ROUND) >>> vru_pkg::GUARD;
    assign yr = (rot_chain[CORDIC_STEPS].y + ROUND) >>> vru_pkg::GUARD;

    always_comb begin
        clip_x = 1'b1;
        clip_y = 1'b1;
        priority if (xr > SAT_HI) begin
            n_out.x_out = vru_pkg::OUT_MAX;
        end else if (xr < SAT_LO) begin
            n_out.x_out = vru_pkg::OUT_MIN;
        end else begin
            n_out.x_out = xr[vru_pkg::COMP_W-1:0];
            clip_x      = 1'b0;
        end
        priority if (yr > SAT_HI) begin
            n_out.y_out = vru_pkg::OUT_MAX;
        end else if (yr < SAT_LO) begin
            n_out.y_out = vru_pkg::OUT_MIN;
        end else begin
            n_out.y_out = yr[vru_pkg::COMP_W-1:0];
            clip_y      = 1'b0;
        end
        n_out.saturated = clip_x | clip_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= vld_chain[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic s1_z_ok;
    logic s2_z_ok;
    logic out_at_limit;

    assign s1_z_ok = (r_s1_z <= vru_pkg::ANG_PI) && (r_s1_z >= NEG_PI);
    assign s2_z_ok = (r_s2_z <= vru_pkg::ANG_HALF_PI) && (r_s2_z >= NEG_HALF_PI);
    assign out_at_limit = (r_out.x_out == vru_pkg::OUT_MAX) || (r_out.x_out == vru_pkg::OUT_MIN)
                       || (r_out.y_out == vru_pkg::OUT_MAX) || (r_out.y_out == vru_pkg::OUT_MIN);

    `VRU_ASSERT_SAME(a_reduced_range, r_s1_vld, s1_z_ok, "reduced angle outside pi range")
    `VRU_ASSERT_SAME(a_folded_range, r_s2_vld, s2_z_ok, "folded angle outside half pi range")
    `VRU_ASSERT_NEXT(a_front_flow, r_s1_vld, r_s2_vld, "word lost in front stages")
    `VRU_ASSERT_NEXT(a_tail_flow, vld_chain[CORDIC_STEPS], r_out_vld, "word lost at output")
    `VRU_ASSERT_SAME(a_sat_clip, r_out_vld && r_out.saturated, out_at_limit, "saturated w/o clip")
    `VRU_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

[bench/vru_checker.sv]
// ----------------------------------------------------------------------------
// vru_checker
// Watches the command and result channels of the vector rotator. Every word
// taken in is rotated by a bit-exact CORDIC model and queued, and every
// result word is compared field by field with the oldest queued rotation.
// ----------------------------------------------------------------------------
module vru_checker #(
    parameter int STEPS = vru_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  vru_pkg::t_vru_in  i_data,
    input  logic              i_valid,
    input  vru_pkg::t_vru_out i_result,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    // Q.30 angle constants and the gain in Q0.30
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     GUARD_BITS  = 8;
    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_LO      = -64'sd2147483648;

    vru_pkg::t_vru_out rotated_q [$];
    int                fail_cnt;
    int                n_checked;
    int                n_clipped;

    // atan(2^-i), truncated to Q.30
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 64'h3243F6A8;
            1:  return 64'h1DAC6705;
            2:  return 64'h0FADBAFC;
            3:  return 64'h07F56EA6;
            4:  return 64'h03FEAB76;
            5:  return 64'h01FFD55B;
            6:  return 64'h00FFFAAA;
            7:  return 64'h007FFF55;
            8:  return 64'h003FFFEA;
            9:  return 64'h001FFFFD;
            10: return 64'h000FFFFF;
            11: return 64'h0007FFFF;
            12: return 64'h0003FFFF;
            13: return 64'h0001FFFF;
            14: return 64'h0000FFFF;
            15: return 64'h00007FFF;
            16: return 64'h00003FFF;
            17: return 64'h00001FFF;
            18: return 64'h00000FFF;
            19: return 64'h000007FF;
            20: return 64'h000003FF;
            21: return 64'h000001FF;
            22: return 64'h000000FF;
            23: return 64'h0000007F;
            24: return 64'h0000003F;
            25: return 64'h0000001F;
            26: return 64'h0000000F;
            27: return 64'h00000008;
            28: return 64'h00000004;
            29: return 64'h00000002;
            30: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // |v| * K into Q.24, rounded toward zero; magnitude split 24 bits up
    function automatic longint gain_scale(input longint v);
        longint mag;
        longint prod;
        mag  = (v < 0) ? -v : v;
        prod = (mag >> 24) * GAIN_Q30 * 4 + (((mag & 64'hFF_FFFF) * GAIN_Q30) >> 22);
        return (v < 0) ? -prod : prod;
    endfunction

    // Drop guard bits (half rounds up) and clip to 32 bits
    function automatic logic signed [31:0] round_clip(input longint v, inout logic clip);
        longint r;
        r = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (r > SAT_HI) begin
            clip = 1'b1;
            r    = SAT_HI;
        end else if (r < SAT_LO) begin
            clip = 1'b1;
            r    = SAT_LO;
        end
        return 32'(r);
    endfunction

    // Full rotation of one command word
    function automatic vru_pkg::t_vru_out rotate_word(input vru_pkg::t_vru_in w);
        longint            x;
        longint            y;
        longint            z;
        longint            dx;
        longint            dy;
        logic              clip;
        vru_pkg::t_vru_out res;
        x    = longint'($signed(w.x_in));
        y    = longint'($signed(w.y_in));
        z    = longint'($signed(w.angle)) * 4;
        clip = 1'b0;

        // wrap into [-pi, pi], exact +-pi stays
        if (z > PI_Q30)
            z = z - TWO_PI_Q30;
        else if (z < -PI_Q30)
            z = z + TWO_PI_Q30;

        // fold into the right half plane by negating the vector
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            x = -x;
            y = -y;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            x = -x;
            y = -y;
        end

        x = gain_scale(x);
        y = gain_scale(y);

        // micro-rotations; a zero residual turns the positive way
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end

        res.x_out     = round_clip(x, clip);
        res.y_out     = round_clip(y, clip);
        res.saturated = clip;
        return res;
    endfunction

    // Compare results against the queue, then queue the word taken this edge
    always @(posedge i_clk) begin : watch
        vru_pkg::t_vru_out exp_w;
        if (!i_rst_n) begin
            rotated_q.delete();
        end else begin
            if (i_valid) begin
                if (rotated_q.size() == 0) begin
                    $error("result word with nothing outstanding: x_out %0d y_out %0d",
                           i_result.x_out, i_result.y_out);
                    fail_cnt++;
                end else begin
                    exp_w = rotated_q.pop_front();
                    n_checked++;
                    if (exp_w.saturated)
                        n_clipped++;
                    if (i_result.x_out !== exp_w.x_out) begin
                        $error("x_out: expected %0d, got %0d", exp_w.x_out, i_result.x_out);
                        fail_cnt++;
                    end
                    if (i_result.y_out !== exp_w.y_out) begin
                        $error("y_out: expected %0d, got %0d", exp_w.y_out, i_result.y_out);
                        fail_cnt++;
                    end
                    if (i_result.saturated !== exp_w.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               exp_w.saturated, i_result.saturated);
                        fail_cnt++;
                    end
                end
            end
            if (i_start && !i_busy)
                rotated_q.push_back(rotate_word(i_data));
        end
        o_errors  <= fail_cnt;
        o_pending <= rotated_q.size();
        o_checked <= n_checked;
        o_clipped <= n_clipped;
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the vector rotator with a directed set of edge angles and extreme
// components, then random words with random gaps and back-to-back bursts.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 500;
    localparam int CYCLE_LIMIT = 60000;
    localparam int TAIL_CYCLES = vru_pkg::CORDIC_STEPS_DEF + 12;

    // Q16.16 and Q4.28 stimulus points
    localparam logic signed [31:0] ONE        = 32'sh0001_0000;
    localparam logic signed [31:0] C_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] A_QTR_PI   = 32'sd210828714;
    localparam logic signed [31:0] A_PI_LO    = 32'sd843314856;
    localparam logic signed [31:0] A_PI_HI    = 32'sd843314857;
    localparam logic signed [31:0] A_HALF_LO  = 32'sd421657428;
    localparam logic signed [31:0] A_HALF_HI  = 32'sd421657429;
    localparam logic signed [31:0] A_TWO_PI   = 32'sd1686629713;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    vru_pkg::t_vru_in  i_data;
    logic              o_valid;
    vru_pkg::t_vru_out o_data;

    int errors;
    int pending;
    int checked;
    int clipped;
    int cycles;
    int burst_left;
    int n_directed;
    int n_sent;

    vector_rotator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    vru_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_data   (i_data),
        .i_valid  (o_valid),
        .i_result (o_data),
        .o_errors (errors),
        .o_pending(pending),
        .o_checked(checked),
        .o_clipped(clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("vector_rotator_unit: mismatch");
            $finish;
        end
    end

    // Present one word after a random gap, or none inside a burst
    task automatic send_word(input vru_pkg::t_vru_in w);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 30);
        end
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    // Component of random magnitude, full range down to a few LSBs
    function automatic logic signed [31:0] rand_comp();
        return $signed($urandom) >>> $urandom_range(0, 24);
    endfunction

    initial begin
        vru_pkg::t_vru_in w;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_data     = '0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero, unit and extreme components
        send_word(vru_pkg::t_vru_in'{32'sd0, 32'sd0, 32'sd0});
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, 32'sd0});
        send_word(vru_pkg::t_vru_in'{C_MAX, 32'sd0, 32'sd0});
        send_word(vru_pkg::t_vru_in'{C_MIN, 32'sd0, 32'sd0});
        send_word(vru_pkg::t_vru_in'{32'sd0, C_MAX, 32'sd0});
        send_word(vru_pkg::t_vru_in'{32'sd0, C_MIN, 32'sd0});
        send_word(vru_pkg::t_vru_in'{-32'sd1, 32'sd1, 32'sd1});
        // diagonal growth past full scale clips
        send_word(vru_pkg::t_vru_in'{C_MAX, C_MAX, A_QTR_PI});
        send_word(vru_pkg::t_vru_in'{C_MIN, C_MIN, A_QTR_PI});
        // angle extremes
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, C_MAX});
        send_word(vru_pkg::t_vru_in'{ONE, ONE, C_MIN});
        send_word(vru_pkg::t_vru_in'{C_MAX, C_MIN, C_MAX});
        // either side of +-pi: kept versus wrapped
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, A_PI_LO});
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, A_PI_HI});
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, -A_PI_LO});
        send_word(vru_pkg::t_vru_in'{ONE, 32'sd0, -A_PI_HI});
        // either side of +-pi/2: direct versus folded
        send_word(vru_pkg::t_vru_in'{ONE, ONE, A_HALF_LO});
        send_word(vru_pkg::t_vru_in'{ONE, ONE, A_HALF_HI});
        send_word(vru_pkg::t_vru_in'{ONE, ONE, -A_HALF_LO});
        send_word(vru_pkg::t_vru_in'{ONE, ONE, -A_HALF_HI});
        // exactly 2*pi wraps to a zero residual
        send_word(vru_pkg::t_vru_in'{ONE, -ONE, A_TWO_PI});
        send_word(vru_pkg::t_vru_in'{-ONE, ONE, -A_TWO_PI});
        // fold negates the most negative radius
        send_word(vru_pkg::t_vru_in'{C_MIN, 32'sd0, A_PI_HI});
        n_directed = n_sent;

        // random vectors; a quarter are polar (y = 0)
        for (int k = 0; k < N_RANDOM; k++) begin
            w.angle = $urandom;
            w.x_in  = rand_comp();
            w.y_in  = ($urandom_range(0, 3) == 0) ? 32'sd0 : rand_comp();
            send_word(w);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // drain, then let any stray word show
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d words rotated (%0d directed, %0d random); %0d compared, %0d clipped",
                 n_sent, n_directed, n_sent - n_directed, checked, clipped);
        if (errors == 0)
            $display("vector_rotator_unit: match");
        else
            $display("vector_rotator_unit: mismatch");
        $finish;
    end

endmodule
